@@ hw/rtl/gql_pkg.sv @@
package gql_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam logic [15:0] SCALE_RESET = 16'd256;

	localparam int QDEPTH = 2;

	localparam logic [7:0] LEAD_TWO_BYTE = 8'd195;
	localparam logic [7:0] LEAD_BIAS = 8'd131;
	localparam logic [7:0] ASCII_MAX = 8'd127;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;

	localparam int TEX_ONE = 65536;

	localparam int VTX_PER_GLYPH = 6;
	localparam logic [2:0] VTX_LAST = 3'(VTX_PER_GLYPH - 1);
	// per-vertex corner select, bit i for vertex i
	localparam logic [5:0] VTX_XHI = 6'b110100;
	localparam logic [5:0] VTX_YHI = 6'b101001;

	typedef enum logic [2:0] {
		MODE_WRITE = 3'd0,
		MODE_MID   = 3'd1,
		MODE_FIRST = 3'd2,
		MODE_LAST  = 3'd3,
		MODE_SOLE  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_DRAW,
		CMD_NEWLINE,
		CMD_NOP
	} kind_t;

	typedef struct packed {
		logic signed [15:0] width;
		logic signed [15:0] height;
		logic signed [15:0] bear_x;
		logic signed [15:0] bear_y;
		logic signed [15:0] advance;
		logic [16:0] s_org;
		logic [16:0] s_span;
		logic [16:0] t_org;
		logic [16:0] t_span;
	} glyph_t;

	typedef struct packed {
		kind_t kind;
		logic clear;
		logic [7:0] code;
		glyph_t glyph;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic [7:0] lead;
	} pend_t;

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		logic signed [43:0] hi;
		logic signed [43:0] lo;
		hi = 44'sh0007fffffff;
		lo = -44'sh00080000000;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
		logic signed [19:0] hi;
		logic signed [19:0] lo;
		hi = 20'sd131071;
		lo = -20'sd131072;
		if (v > hi) begin
			return 18'sh1ffff;
		end else if (v < lo) begin
			return 18'sh20000;
		end
		return v[17:0];
	endfunction

endpackage

@@ hw/rtl/gql_in_if.sv @@
interface gql_in_if;
	logic valid;
	logic ready;
	logic [2:0] mode;
	logic [7:0] code;
	logic signed [15:0] glyph_width;
	logic signed [15:0] glyph_height;
	logic signed [15:0] bearing_x;
	logic signed [15:0] bearing_y;
	logic signed [15:0] pen_advance;
	logic [16:0] tex_s_origin;
	logic [16:0] tex_t_origin;
	logic [16:0] tex_s_span;
	logic [16:0] tex_t_span;

	modport source (
		output valid, mode, code, glyph_width, glyph_height, bearing_x, bearing_y,
			pen_advance, tex_s_origin, tex_t_origin, tex_s_span, tex_t_span,
		input ready
	);
	modport sink (
		input valid, mode, code, glyph_width, glyph_height, bearing_x, bearing_y,
			pen_advance, tex_s_origin, tex_t_origin, tex_s_span, tex_t_span,
		output ready
	);
endinterface

@@ hw/rtl/gql_out_if.sv @@
interface gql_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [17:0] tex_s;
	logic signed [17:0] tex_t;
	logic [31:0] vertex_index;
	logic last_vertex;

	modport source (
		output valid, pos_x, pos_y, tex_s, tex_t, vertex_index, last_vertex,
		input ready
	);
	modport sink (
		input valid, pos_x, pos_y, tex_s, tex_t, vertex_index, last_vertex,
		output ready
	);
endinterface

@@ hw/rtl/gql_cfg_if.sv @@
interface gql_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] text_scale;

	modport source (output valid, text_scale, input ready);
	modport sink (input valid, text_scale, output ready);
endinterface

@@ hw/rtl/gql_fifo.sv @@
module gql_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gql_pkg::cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output gql_pkg::cmd_t rd_cmd,
	output logic empty
);

	localparam int AW = (gql_pkg::QDEPTH > 1) ? $clog2(gql_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(gql_pkg::QDEPTH + 1);

	gql_pkg::cmd_t entry_q [gql_pkg::QDEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(gql_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(gql_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(gql_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/gql_front.sv @@
module gql_front (
	input  logic clk,
	input  logic arst_n,
	gql_in_if.sink din,
	input  logic q_full,
	output logic q_push,
	output gql_pkg::cmd_t q_cmd
);

	gql_pkg::pend_t pend_q;
	gql_pkg::pend_t pend_d;
	logic accept;
	logic clear;
	logic last_byte;
	logic [7:0] sym;

	assign din.ready = !q_full;
	assign accept = din.valid && din.ready;

	always_comb begin
		q_push = 1'b0;
		q_cmd = '0;
		q_cmd.kind = gql_pkg::CMD_NOP;
		q_cmd.code = din.code;
		q_cmd.glyph.width = din.glyph_width;
		q_cmd.glyph.height = din.glyph_height;
		q_cmd.glyph.bear_x = din.bearing_x;
		q_cmd.glyph.bear_y = din.bearing_y;
		q_cmd.glyph.advance = din.pen_advance;
		q_cmd.glyph.s_org = din.tex_s_origin;
		q_cmd.glyph.s_span = din.tex_s_span;
		q_cmd.glyph.t_org = din.tex_t_origin;
		q_cmd.glyph.t_span = din.tex_t_span;
		pend_d = pend_q;
		clear = (din.mode == gql_pkg::MODE_FIRST) || (din.mode == gql_pkg::MODE_SOLE);
		last_byte = (din.mode == gql_pkg::MODE_LAST) || (din.mode == gql_pkg::MODE_SOLE);
		sym = din.code;
		if (accept) begin
			unique case (gql_pkg::mode_t'(din.mode))
				gql_pkg::MODE_WRITE: begin
					q_push = 1'b1;
					q_cmd.kind = gql_pkg::CMD_WRITE;
				end
				gql_pkg::MODE_MID, gql_pkg::MODE_FIRST, gql_pkg::MODE_LAST,
				gql_pkg::MODE_SOLE: begin
					q_cmd.clear = clear;
					if (pend_q.valid && !clear) begin
						// two-byte sequence completes on this word
						if (pend_q.lead == gql_pkg::LEAD_TWO_BYTE) begin
							sym = din.code + (gql_pkg::LEAD_TWO_BYTE - gql_pkg::LEAD_BIAS);
						end
						pend_d = '0;
						q_push = 1'b1;
						q_cmd.code = sym;
						q_cmd.kind = (sym == gql_pkg::CODE_NEWLINE) ? gql_pkg::CMD_NEWLINE
							: gql_pkg::CMD_DRAW;
					end else if (din.code > gql_pkg::ASCII_MAX && !last_byte) begin
						pend_d.valid = 1'b1;
						pend_d.lead = din.code;
						// text start still has to reset the pen
						q_push = clear;
						q_cmd.kind = gql_pkg::CMD_NOP;
					end else begin
						pend_d = '0;
						q_push = 1'b1;
						q_cmd.kind = (din.code == gql_pkg::CODE_NEWLINE) ? gql_pkg::CMD_NEWLINE
							: gql_pkg::CMD_DRAW;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_d;
		end
	end

endmodule

@@ hw/rtl/gql_back.sv @@
module gql_back #(
	parameter int GLYPH_COUNT = gql_pkg::GLYPH_COUNT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0] scale,
	input  logic q_empty,
	input  gql_pkg::cmd_t q_head,
	output logic q_pop,
	gql_out_if.source dout
);

	localparam int GIW = $clog2(GLYPH_COUNT);

	// glyph table
	gql_pkg::glyph_t glyph_mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0] gvalid_q;
	logic head_in_range;
	logic [GIW-1:0] head_idx;

	// stage 1: table read
	logic v_s1;
	gql_pkg::kind_t kind_s1;
	logic clear_s1;
	logic hit_s1;
	gql_pkg::glyph_t rd_s1;

	// stage 2: operands
	logic v_s2;
	logic signed [32:0] sumx_s2;
	logic signed [15:0] w_s2;
	logic signed [16:0] dh_s2;
	logic signed [15:0] h_s2;
	logic signed [31:0] py_s2;
	logic [17:0] s0_s2;
	logic [17:0] s1_s2;
	logic signed [17:0] t0_s2;
	logic signed [17:0] t1_s2;
	logic [31:0] base_s2;

	// stage 3: scaled products
	logic v_s3;
	logic signed [49:0] px_s3;
	logic signed [32:0] pw_s3;
	logic signed [33:0] pd_s3;
	logic signed [32:0] ph_s3;
	logic signed [31:0] py_s3;
	logic [17:0] s0_s3;
	logic [17:0] s1_s3;
	logic signed [17:0] t0_s3;
	logic signed [17:0] t1_s3;
	logic [31:0] base_s3;

	// quad under emission
	logic v_g_q;
	logic [2:0] cnt_q;
	logic signed [31:0] x0_q, x1_q, y0_q, y1_q;
	logic [17:0] s0_q, s1_q;
	logic signed [17:0] t0_q, t1_q;
	logic [31:0] base_q;

	// output register
	logic ov_q;
	logic signed [31:0] ox_q, oy_q;
	logic [17:0] os_q;
	logic signed [17:0] ot_q;
	logic [31:0] oidx_q;
	logic olast_q;

	// pen state
	logic signed [31:0] pen_x_q;
	logic signed [31:0] pen_y_q;
	logic [31:0] vc_q;

	logic fire1, draw1, adv2, load_g, o_load, ready2, ready3;
	gql_pkg::glyph_t g1;
	logic signed [31:0] px_base, py_base;
	logic [31:0] vc_base;
	logic signed [32:0] sumx1;
	logic signed [16:0] dh1;
	logic [17:0] s1v;
	logic signed [19:0] t0w, tt0, tt1;
	logic signed [31:0] pen_x_adv, pen_y_nl;
	logic signed [16:0] scale_sg;
	logic signed [41:0] x0f;
	logic signed [24:0] wf;
	logic signed [25:0] df;
	logic signed [24:0] hf;
	logic signed [43:0] y0w;
	logic xhi, yhi;

	assign head_in_range = {1'b0, q_head.code} < 9'(GLYPH_COUNT);
	assign head_idx = q_head.code[GIW-1:0];

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == gql_pkg::CMD_WRITE && head_in_range) begin
			glyph_mem[head_idx] <= q_head.glyph;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= glyph_mem[head_idx];
		end
	end

	// handshake between stages
	assign o_load = v_g_q && (!ov_q || dout.ready);
	assign load_g = v_s3 && (!v_g_q || (o_load && cnt_q == gql_pkg::VTX_LAST));
	assign ready3 = !v_s3 || load_g;
	assign ready2 = !v_s2 || ready3;
	assign adv2 = v_s2 && ready3;
	assign fire1 = v_s1 && (kind_s1 != gql_pkg::CMD_DRAW || ready2);
	assign draw1 = fire1 && kind_s1 == gql_pkg::CMD_DRAW;
	assign q_pop = !q_empty && (!v_s1 || fire1);

	always_comb begin
		g1 = hit_s1 ? rd_s1 : '0;
		px_base = clear_s1 ? '0 : pen_x_q;
		py_base = clear_s1 ? '0 : pen_y_q;
		vc_base = clear_s1 ? '0 : vc_q;
		sumx1 = 33'(px_base) + 33'(g1.bear_x);
		dh1 = 17'(g1.bear_y) - 17'(g1.height);
		s1v = 18'(g1.s_org) + 18'(g1.s_span);
		t0w = $signed({3'b000, g1.t_org});
		tt0 = 20'(gql_pkg::TEX_ONE) - t0w;
		tt1 = tt0 - $signed({3'b000, g1.t_span});
		pen_x_adv = gql_pkg::sat32(44'(px_base) + 44'(g1.advance));
		pen_y_nl = gql_pkg::sat32(44'(py_base) - $signed(44'({scale, 4'b0000})));
	end

	assign scale_sg = $signed({1'b0, scale});

	// floor back from Q.20 to Q.12 is an arithmetic shift
	assign x0f = px_s3[49:8];
	assign wf = pw_s3[32:8];
	assign df = pd_s3[33:8];
	assign hf = ph_s3[32:8];
	assign y0w = 44'(py_s3) + 44'(df);

	assign xhi = gql_pkg::VTX_XHI[cnt_q];
	assign yhi = gql_pkg::VTX_YHI[cnt_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvalid_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_g_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			pen_x_q <= '0;
			pen_y_q <= '0;
			vc_q <= '0;
		end else begin
			if (q_pop && q_head.kind == gql_pkg::CMD_WRITE && head_in_range) begin
				gvalid_q[head_idx] <= 1'b1;
			end
			if (q_pop) begin
				v_s1 <= 1'b1;
			end else if (fire1) begin
				v_s1 <= 1'b0;
			end
			if (fire1) begin
				unique case (kind_s1)
					gql_pkg::CMD_DRAW: begin
						pen_x_q <= pen_x_adv;
						pen_y_q <= py_base;
						vc_q <= vc_base + 32'(gql_pkg::VTX_PER_GLYPH);
					end
					gql_pkg::CMD_NEWLINE: begin
						pen_x_q <= '0;
						pen_y_q <= pen_y_nl;
						vc_q <= vc_base;
					end
					gql_pkg::CMD_NOP, gql_pkg::CMD_WRITE: begin
						pen_x_q <= px_base;
						pen_y_q <= py_base;
						vc_q <= vc_base;
					end
				endcase
			end
			if (draw1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (load_g) begin
				v_s3 <= 1'b0;
			end
			if (load_g) begin
				v_g_q <= 1'b1;
				cnt_q <= '0;
			end else if (o_load) begin
				if (cnt_q == gql_pkg::VTX_LAST) begin
					v_g_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (o_load) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_s1 <= q_head.kind;
			clear_s1 <= q_head.clear;
			hit_s1 <= head_in_range && gvalid_q[head_idx];
		end
		if (draw1) begin
			sumx_s2 <= sumx1;
			w_s2 <= g1.width;
			dh_s2 <= dh1;
			h_s2 <= g1.height;
			py_s2 <= py_base;
			s0_s2 <= 18'(g1.s_org);
			s1_s2 <= s1v;
			t0_s2 <= tt0[17:0];
			t1_s2 <= gql_pkg::sat18(tt1);
			base_s2 <= vc_base;
		end
		if (adv2) begin
			px_s3 <= scale_sg * sumx_s2;
			pw_s3 <= scale_sg * w_s2;
			pd_s3 <= scale_sg * dh_s2;
			ph_s3 <= scale_sg * h_s2;
			py_s3 <= py_s2;
			s0_s3 <= s0_s2;
			s1_s3 <= s1_s2;
			t0_s3 <= t0_s2;
			t1_s3 <= t1_s2;
			base_s3 <= base_s2;
		end
		if (load_g) begin
			x0_q <= gql_pkg::sat32(44'(x0f));
			x1_q <= gql_pkg::sat32(44'(x0f) + 44'(wf));
			y0_q <= gql_pkg::sat32(y0w);
			y1_q <= gql_pkg::sat32(y0w + 44'(hf));
			s0_q <= s0_s3;
			s1_q <= s1_s3;
			t0_q <= t0_s3;
			t1_q <= t1_s3;
			base_q <= base_s3;
		end
		if (o_load) begin
			ox_q <= xhi ? x1_q : x0_q;
			os_q <= xhi ? s1_q : s0_q;
			oy_q <= yhi ? y1_q : y0_q;
			ot_q <= yhi ? t0_q : t1_q;
			oidx_q <= base_q + 32'(cnt_q);
			olast_q <= (cnt_q == gql_pkg::VTX_LAST);
		end
	end

	assign dout.valid = ov_q;
	assign dout.pos_x = ox_q;
	assign dout.pos_y = oy_q;
	assign dout.tex_s = os_q;
	assign dout.tex_t = ot_q;
	assign dout.vertex_index = oidx_q;
	assign dout.last_vertex = olast_q;

	a_quad_reload: assert property (@(posedge clk) disable iff (!arst_n)
		load_g |-> (!v_g_q || cnt_q == gql_pkg::VTX_LAST))
		else $error("quad register reloaded before its last vertex left");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_g_q |-> cnt_q <= gql_pkg::VTX_LAST)
		else $error("vertex counter out of range");

	a_vc_step: assert property (@(posedge clk) disable iff (!arst_n)
		draw1 |=> vc_q == $past(vc_base) + 32'(gql_pkg::VTX_PER_GLYPH))
		else $error("vertex count not advanced by one quad");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty command queue");

endmodule

@@ hw/rtl/glyph_quad_layout.sv @@
// Glyph quad layout: turns a byte stream of text into textured quad vertices.
// din: one word per glyph-table write (mode 0) or text byte (modes 1..4);
//   modes 5..7 are taken and dropped. Valid/ready, taken when both are high.
// dout: one vertex per word, six per drawn glyph, last_vertex on the sixth.
// cfg: write-only text_scale (Q8.8); ready is always high. Write it only
//   while the block is idle.
// Path: a text byte passes the command queue, then the table read, operand,
//   multiply, quad and output registers before its first vertex shows on dout.
// Throughput: a drawn glyph holds the vertex sequencer for all six vertices,
//   one vertex per cycle while dout is ready; writes, newlines and held lead
//   bytes never reach it. A 2-entry command queue between the byte decoder and
//   the vertex pipeline keeps din flowing while dout is stalled until it fills.
// Reset: glyph table reads as all zero (per-entry valid bits), pen and
//   vertex count at zero, no lead byte pending, text_scale = 1.0.
// Stall: when dout.ready is low the output register holds its vertex and the
//   pipeline backs up stage by stage; nothing is dropped.
module glyph_quad_layout #(
	parameter int GLYPH_COUNT = gql_pkg::GLYPH_COUNT
) (
	input logic clk,
	input logic arst_n,
	gql_in_if.sink din,
	gql_out_if.source dout,
	gql_cfg_if.sink cfg
);

	logic [15:0] scale_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	gql_pkg::cmd_t q_wr_cmd;
	gql_pkg::cmd_t q_rd_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= gql_pkg::SCALE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			scale_q <= cfg.text_scale;
		end
	end

	gql_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_wr_cmd)
	);

	gql_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	gql_back #(
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.scale   (scale_q),
		.q_empty (q_empty),
		.q_head  (q_rd_cmd),
		.q_pop   (q_pop),
		.dout    (dout)
	);

endmodule
